@@ rtl/pcgrr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcgrr_pkg
// Shared constants and types for the PCG random generator with ranged actions.
// ----------------------------------------------------------------------------
package pcgrr_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned HalfW = DataW / 2;

  localparam logic [DataW-1:0] LcgMul  = 64'd6364136223846793005;
  localparam logic [DataW-1:0] LcgInc  = 64'd1442695040888963407;
  localparam logic [DataW-1:0] PermMul = 64'd12605985483714917081;

  // RXS-M-XS shift amounts
  localparam int unsigned RxsSel  = 59;
  localparam logic [5:0]  RxsBase = 6'd5;
  localparam int unsigned XsShift = 43;

  typedef enum logic [2:0] {
    ACT_RAW  = 3'd0,
    ACT_BERN = 3'd1,
    ACT_UNI  = 3'd2,
    ACT_SKEW = 3'd3,
    ACT_AVG  = 3'd4
  } action_e;

  // start request / completion between the sequencer and an arithmetic unit
  typedef struct packed {
    logic start;
  } unit_req_t;

  typedef struct packed {
    logic done;
  } unit_rsp_t;

endpackage

@@ rtl/pcgrr_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcgrr_mul
// Iterative 64x64 multiplier, low 64 bits of the product, built from one
// 32x32 multiplier used for the low term and then the two cross terms.
// ----------------------------------------------------------------------------
module pcgrr_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pcgrr_pkg::unit_req_t       req_i,
  input  logic [pcgrr_pkg::DataW-1:0] a_i,
  input  logic [pcgrr_pkg::DataW-1:0] b_i,
  output pcgrr_pkg::unit_rsp_t       rsp_o,
  output logic [pcgrr_pkg::DataW-1:0] prod_o
);
  import pcgrr_pkg::*;

  logic [DataW-1:0] a_q, b_q, acc_q, acc_d;
  logic [1:0]       step_q;
  logic             busy_q, done_q;
  logic [HalfW-1:0] op_a, op_b;
  logic [DataW-1:0] part;

  // partial products: lo*lo, then the two cross terms (only their low half lands)
  always_comb begin
    case (step_q)
      2'd0:    begin op_a = a_q[HalfW-1:0];     op_b = b_q[HalfW-1:0];     end
      2'd1:    begin op_a = a_q[HalfW-1:0];     op_b = b_q[DataW-1:HalfW]; end
      default: begin op_a = a_q[DataW-1:HalfW]; op_b = b_q[HalfW-1:0];     end
    endcase
  end

  assign part = op_a * op_b;

  always_comb begin
    if (step_q == 2'd0) begin
      acc_d = part;
    end else begin
      acc_d = acc_q + {part[HalfW-1:0], {HalfW{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= 2'd0;
      end else if (busy_q) begin
        if (step_q == 2'd2) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          step_q <= 2'd0;
        end else begin
          step_q <= step_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign rsp_o.done = done_q;
  assign prod_o     = acc_q;

endmodule

@@ rtl/pcgrr_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcgrr_div
// Radix-2 restoring modulo unit: one remainder bit per cycle.
// ----------------------------------------------------------------------------
module pcgrr_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pcgrr_pkg::unit_req_t        req_i,
  input  logic [pcgrr_pkg::DataW-1:0] num_i,
  input  logic [pcgrr_pkg::DataW-1:0] den_i,
  output pcgrr_pkg::unit_rsp_t        rsp_o,
  output logic [pcgrr_pkg::DataW-1:0] rem_o
);
  import pcgrr_pkg::*;

  localparam int unsigned CntW = $clog2(DataW);

  logic [DataW-1:0] num_q, den_q, rem_q, rem_d;
  logic [DataW:0]   trial;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;

  // shift in the next numerator bit, subtract the divisor when it fits
  assign trial = {rem_q, num_q[DataW-1]};
  always_comb begin
    if (trial >= {1'b0, den_q}) begin
      rem_d = DataW'(trial - {1'b0, den_q});
    end else begin
      rem_d = trial[DataW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DataW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[DataW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rem_o      = rem_q;

endmodule

@@ rtl/pcg_random_with_ranges.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcg_random_with_ranges
// PCG RXS-M-XS 64/64 generator with raw, Bernoulli, uniform, skewed and
// two-draw average actions, sequenced over a shared multiplier and modulo unit.
// ----------------------------------------------------------------------------
// Sequence: a draw is two passes through the multiplier (LCG step, then the
//   permutation); each ranged draw adds a pass through the bit-serial modulo
//   unit. Raw and Bernoulli take one draw, uniform one ranged draw, skewed and
//   average two; an empty range or unknown action goes straight to S_DONE.
// Throughput: one transaction at a time; in_ready_o is high only when idle.
// Reset: state and seed load to zero, no result pending.
// ----------------------------------------------------------------------------
module pcg_random_with_ranges (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pcgrr_pkg::DataW-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  action_i,
  input  logic [pcgrr_pkg::DataW-1:0] low_bound_i,
  input  logic [pcgrr_pkg::DataW-1:0] high_bound_i,
  input  logic [pcgrr_pkg::DataW-1:0] prob_threshold_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [pcgrr_pkg::DataW-1:0] value_o,
  output logic                        hit_o,
  output logic                        error_o
);
  import pcgrr_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_LCG_GO    = 8'b0000_0010,
    S_LCG_WAIT  = 8'b0000_0100,
    S_PERM_GO   = 8'b0000_1000,
    S_PERM_WAIT = 8'b0001_0000,
    S_MOD_GO    = 8'b0010_0000,
    S_MOD_WAIT  = 8'b0100_0000,
    S_DONE      = 8'b1000_0000
  } fsm_e;

  fsm_e             fsm_q, fsm_d;
  logic [DataW-1:0] gen_q;
  logic [2:0]       action_q;
  logic [DataW-1:0] lo_q, thr_q;
  logic [DataW-1:0] range_q, draw_q, first_q;
  logic             second_q;
  logic [DataW-1:0] res_value_q;
  logic             res_hit_q, res_err_q;
  logic [DataW-1:0] value_q;
  logic             hit_q, err_q, out_valid_q;

  unit_req_t        mul_req, div_req;
  unit_rsp_t        mul_rsp, div_rsp;
  logic [DataW-1:0] mul_a, mul_b, mul_prod, div_rem;
  logic [5:0]       rxs_amt;
  logic [DataW-1:0] rxs, perm_out, uni, avg;
  logic             accept, ranged, out_free;

  assign accept   = in_valid_i && in_ready_o;
  assign ranged   = action_i inside {ACT_UNI, ACT_SKEW, ACT_AVG};
  assign out_free = !out_valid_q || out_ready_i;

  // random xorshift on the fresh state
  assign rxs_amt  = {1'b0, gen_q[DataW-1:RxsSel]} + RxsBase;
  assign rxs      = (gen_q >> rxs_amt) ^ gen_q;
  assign perm_out = (mul_prod >> XsShift) ^ mul_prod;
  assign uni      = div_rem + lo_q;
  assign avg      = (first_q >> 1) + (uni >> 1) + {{(DataW-1){1'b0}}, first_q[0] & uni[0]};

  assign mul_req.start = (fsm_q == S_LCG_GO) || (fsm_q == S_PERM_GO);
  assign mul_a         = (fsm_q == S_LCG_GO) ? gen_q : rxs;
  assign mul_b         = (fsm_q == S_LCG_GO) ? LcgMul : PermMul;
  assign div_req.start = (fsm_q == S_MOD_GO);

  pcgrr_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .rsp_o  (mul_rsp),
    .prod_o (mul_prod)
  );

  pcgrr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .num_i  (draw_q),
    .den_i  (range_q),
    .rsp_o  (div_rsp),
    .rem_o  (div_rem)
  );

  always_comb begin
    fsm_d = fsm_q;
    case (fsm_q)
      S_IDLE: begin
        if (accept) begin
          if (action_i > ACT_AVG || (ranged && low_bound_i >= high_bound_i)) begin
            fsm_d = S_DONE;
          end else begin
            fsm_d = S_LCG_GO;
          end
        end
      end
      S_LCG_GO:    fsm_d = S_LCG_WAIT;
      S_LCG_WAIT:  if (mul_rsp.done) fsm_d = S_PERM_GO;
      S_PERM_GO:   fsm_d = S_PERM_WAIT;
      S_PERM_WAIT: begin
        if (mul_rsp.done) begin
          if (action_q == ACT_RAW || action_q == ACT_BERN) begin
            fsm_d = S_DONE;
          end else begin
            fsm_d = S_MOD_GO;
          end
        end
      end
      S_MOD_GO:    fsm_d = S_MOD_WAIT;
      S_MOD_WAIT: begin
        if (div_rsp.done) begin
          if (action_q == ACT_UNI || second_q) begin
            fsm_d = S_DONE;
          end else begin
            fsm_d = S_LCG_GO;
          end
        end
      end
      S_DONE:      if (out_free) fsm_d = S_IDLE;
      default:     fsm_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= S_IDLE;
      gen_q       <= '0;
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else begin
      fsm_q <= fsm_d;
      if (cfg_we_i) begin
        gen_q <= cfg_wdata_i;
      end else if (fsm_q == S_LCG_WAIT && mul_rsp.done) begin
        gen_q <= mul_prod + LcgInc;
      end
      if (accept) begin
        second_q <= 1'b0;
      end else if (fsm_q == S_MOD_WAIT && div_rsp.done) begin
        second_q <= 1'b1;
      end
      if (fsm_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q    <= action_i;
      lo_q        <= low_bound_i;
      thr_q       <= prob_threshold_i;
      range_q     <= high_bound_i - low_bound_i;
      res_value_q <= '0;
      res_hit_q   <= 1'b0;
      res_err_q   <= ranged && (low_bound_i >= high_bound_i);
    end
    if (fsm_q == S_PERM_WAIT && mul_rsp.done) begin
      draw_q      <= perm_out;
      res_value_q <= perm_out;
      res_hit_q   <= (action_q == ACT_BERN) && (perm_out <= thr_q);
    end
    if (fsm_q == S_MOD_WAIT && div_rsp.done) begin
      first_q <= uni;
      // skewed: second range is (bound - low), bound being the first draw plus one
      if (action_q == ACT_SKEW && !second_q) begin
        range_q <= div_rem + 1'b1;
      end
      if (action_q == ACT_AVG && second_q) begin
        res_value_q <= avg;
      end else begin
        res_value_q <= uni;
      end
    end
    if (fsm_q == S_DONE && out_free) begin
      value_q <= res_value_q;
      hit_q   <= res_hit_q;
      err_q   <= res_err_q;
    end
  end

  assign in_ready_o  = (fsm_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign hit_o       = hit_q;
  assign error_o     = err_q;

endmodule

@@ rtl/pcgrr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcgrr_checker
// Port-level checks for the PCG random generator, bound to the top level.
// ----------------------------------------------------------------------------
module pcgrr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [pcgrr_pkg::DataW-1:0] value_o,
  input logic                        hit_o,
  input logic                        error_o
);
  import pcgrr_pkg::*;

  // one transaction in flight: an accepted request drops ready
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a transaction was still in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_o)
      && $stable(hit_o) && $stable(error_o))
    else $error("pending result changed before it was taken");

  a_err_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> !hit_o && value_o == '0)
    else $error("error result carries a value or hit");

  a_no_result_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared in the cycle after the request");

endmodule

bind pcg_random_with_ranges pcgrr_checker u_pcgrr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .value_o     (value_o),
  .hit_o       (hit_o),
  .error_o     (error_o)
);
